// ===== rtl/wcts_pkg.sv =====
// ----------------------------------------------------------------------------
// wcts_pkg
// Shared widths, codes and types of the wall contact time solver.
// ----------------------------------------------------------------------------
package wcts_pkg;

   localparam int FRAC_BITS = 16;

   localparam int XW       = 32;              // coordinate and register width
   localparam int RADW     = 31;              // radius width
   localparam int SW       = XW + 2;          // gap width, signed
   localparam int UW       = XW + 1;          // rate and acceleration width, signed
   localparam int MW       = XW;              // magnitude of rate or acceleration
   localparam int SPLIT    = SW / 2;          // low slice of the gap magnitude
   localparam int PHW      = SW - SPLIT;      // high slice of the gap magnitude
   localparam int UUW      = 2 * MW;          // rate squared
   localparam int PLW      = MW + SPLIT;
   localparam int PHPW     = MW + PHW;
   localparam int DW       = 2 * SW;          // discriminant width
   localparam int QW       = DW / 2;          // square root width
   localparam int RW       = QW + 3;          // square root remainder width
   localparam int NSW      = QW + 2;          // root numerator width, signed
   localparam int NW       = NSW + FRAC_BITS; // scaled numerator magnitude
   localparam int TW       = 32;              // time width
   localparam int DIV_LAT  = TW + 1;          // divider register stages
   localparam int NWALLS   = 4;
   localparam int CSR_IW   = 2;

   localparam logic signed [63:0] TIME_LIMIT = 64'sd10000000 <<< FRAC_BITS;

   localparam logic [XW-1:0] BOX_LEFT_RESET   = 32'd0;
   localparam logic [XW-1:0] BOX_RIGHT_RESET  = 32'd6553600;
   localparam logic [XW-1:0] BOX_BOTTOM_RESET = 32'd0;
   localparam logic [XW-1:0] BOX_TOP_RESET    = 32'd6553600;

   typedef enum logic [CSR_IW-1:0] {
      CSR_BOX_LEFT   = 2'd0,
      CSR_BOX_RIGHT  = 2'd1,
      CSR_BOX_BOTTOM = 2'd2,
      CSR_BOX_TOP    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      WALL_NONE    = 3'd0,
      WALL_UPPER_X = 3'd1,
      WALL_LOWER_X = 3'd2,
      WALL_UPPER_Y = 3'd3,
      WALL_LOWER_Y = 3'd4
   } wall_code_type;

   typedef struct packed {
      logic                 lin;
      logic                 uneg;
      logic                 aneg;
      logic                 ppos;
      logic signed [UW-1:0] u;
      logic signed [SW-1:0] s;
      logic [MW-1:0]        um;
      logic [MW-1:0]        am;
   } wall_side_type;

   typedef struct packed {
      logic                 ok;
      logic signed [TW-1:0] t;
   } wall_res_type;

   typedef struct packed {
      logic                 ok;
      logic signed [TW-1:0] t;
      wall_code_type        code;
   } pick_type;

endpackage

// ===== rtl/wcts_div.sv =====
// ----------------------------------------------------------------------------
// wcts_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module wcts_div (
   input  logic                      clock,
   input  logic                      en,
   input  logic [wcts_pkg::NW-1:0]   num,
   input  logic [wcts_pkg::MW-1:0]   den,
   output logic [wcts_pkg::TW-1:0]   quo,
   output logic                      ovf
);
   import wcts_pkg::*;

   logic [TW:0]   rem_ff [TW+1];
   logic [TW-1:0] lo_ff  [TW+1];
   logic [TW-1:0] q_ff   [TW+1];
   logic [MW-1:0] den_ff [TW+1];
   logic          ovf_ff [TW+1];

   logic [TW:0]   rem0_in;
   logic          ovf0_in;

   always_comb begin
      rem0_in = (TW+1)'(num[NW-1:TW]);
      ovf0_in = rem0_in >= (TW+1)'(den);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem0_in;
         lo_ff[0]  <= num[TW-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         ovf_ff[0] <= ovf0_in;
      end
   end

   for (genvar k = 1; k <= TW; k++) begin : g_step
      logic [TW:0] sh_in;
      logic        ge_in;
      always_comb begin
         sh_in = {rem_ff[k-1][TW-1:0], lo_ff[k-1][TW-1]};
         ge_in = sh_in >= (TW+1)'(den_ff[k-1]);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge_in ? sh_in - (TW+1)'(den_ff[k-1]) : sh_in;
            lo_ff[k]  <= {lo_ff[k-1][TW-2:0], 1'b0};
            q_ff[k]   <= {q_ff[k-1][TW-2:0], ge_in};
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo = q_ff[TW];
   assign ovf = ovf_ff[TW];

endmodule

// ===== rtl/wcts_wall.sv =====
// ----------------------------------------------------------------------------
// wcts_wall
// Contact time of one wall: discriminant, digit square root, two divisions.
// ----------------------------------------------------------------------------
module wcts_wall (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [wcts_pkg::SW-1:0] wall_s,
   input  logic signed [wcts_pkg::UW-1:0] wall_u,
   input  logic signed [wcts_pkg::UW-1:0] wall_a,
   output logic                           out_valid,
   output wcts_pkg::wall_res_type         res
);
   import wcts_pkg::*;

   // magnitudes and flags
   wall_side_type  sa_in, sa_ff;
   logic           va_ff;
   logic [UW-1:0]  a_abs, u_abs;
   logic [SW-1:0]  s_abs;
   logic           a_pos, s_pos;

   always_comb begin
      a_abs = wall_a[UW-1] ? -wall_a : wall_a;
      u_abs = wall_u[UW-1] ? -wall_u : wall_u;
      s_abs = wall_s[SW-1] ? -wall_s : wall_s;
      a_pos = !wall_a[UW-1] && (wall_a != '0);
      s_pos = !wall_s[SW-1] && (wall_s != '0);
      sa_in.lin  = wall_a == '0;
      sa_in.uneg = wall_u[UW-1];
      sa_in.aneg = wall_a[UW-1];
      sa_in.ppos = (wall_s != '0) && (a_pos == s_pos);
      sa_in.u    = wall_u;
      sa_in.s    = wall_s;
      sa_in.um   = u_abs[MW-1:0];
      sa_in.am   = a_abs[MW-1:0];
   end

   // products
   wall_side_type  sb_ff;
   logic           vb_ff;
   logic [SW-1:0]  sm_ff;
   logic [UUW-1:0] uu_ff;
   logic [PLW-1:0] pl_ff;
   logic [PHPW-1:0] ph_ff;

   // 2*a*s
   wall_side_type  sc_ff;
   logic           vc_ff;
   logic [UUW-1:0] uuc_ff;
   logic [DW-1:0]  p2_ff;

   // discriminant
   wall_side_type  sd_ff;
   logic           vd_ff;
   logic           negd_ff;
   logic [DW-1:0]  d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff   <= sa_in;
         sm_ff   <= s_abs;
         sb_ff   <= sa_ff;
         uu_ff   <= sa_ff.um * sa_ff.um;
         pl_ff   <= sa_ff.am * sm_ff[SPLIT-1:0];
         ph_ff   <= sa_ff.am * sm_ff[SW-1:SPLIT];
         sc_ff   <= sb_ff;
         uuc_ff  <= uu_ff;
         p2_ff   <= ((DW'(ph_ff) << SPLIT) + DW'(pl_ff)) << 1;
         sd_ff   <= sc_ff;
         negd_ff <= sc_ff.ppos && (p2_ff > DW'(uuc_ff));
         d_ff    <= sc_ff.ppos ? DW'(uuc_ff) - p2_ff : DW'(uuc_ff) + p2_ff;
      end
   end

   // square root, two discriminant bits per stage
   logic [RW-1:0]   rem_ff  [QW];
   logic [QW-1:0]   root_ff [QW];
   logic [DW-1:0]   dq_ff   [QW];
   logic            vq_ff   [QW];
   logic            negq_ff [QW];
   wall_side_type   sq_ff   [QW];

   for (genvar k = 0; k < QW; k++) begin : g_sqrt
      logic [RW-1:0] prem;
      logic [QW-1:0] proot;
      logic [DW-1:0] pd;
      logic          pv;
      logic          pneg;
      wall_side_type pside;
      logic [RW-1:0] sh_in;
      logic [RW-1:0] trial_in;
      logic          ge_in;

      if (k == 0) begin : g_first
         assign prem  = '0;
         assign proot = '0;
         assign pd    = d_ff;
         assign pv    = vd_ff;
         assign pneg  = negd_ff;
         assign pside = sd_ff;
      end else begin : g_next
         assign prem  = rem_ff[k-1];
         assign proot = root_ff[k-1];
         assign pd    = dq_ff[k-1];
         assign pv    = vq_ff[k-1];
         assign pneg  = negq_ff[k-1];
         assign pside = sq_ff[k-1];
      end

      always_comb begin
         sh_in    = {prem[RW-3:0], pd[DW-1:DW-2]};
         trial_in = RW'({proot, 2'b01});
         ge_in    = sh_in >= trial_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vq_ff[k] <= 1'b0;
         end else if (en) begin
            vq_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge_in ? sh_in - trial_in : sh_in;
            root_ff[k] <= {proot[QW-2:0], ge_in};
            dq_ff[k]   <= pd << 2;
            negq_ff[k] <= pneg;
            sq_ff[k]   <= pside;
         end
      end
   end

   // numerators and divisor
   wall_side_type         sl;
   logic signed [NSW-1:0] nu, qx, sx, n1, n2;
   logic [NSW-1:0]        m1, m2;
   logic                  vn_ff;
   logic [NW-1:0]         num1_ff, num2_ff;
   logic [MW-1:0]         den_ff;
   logic                  sgn1_in, sgn2_in, nocont_in;

   always_comb begin
      sl = sq_ff[QW-1];
      nu = -$signed({{(NSW-UW){sl.u[UW-1]}}, sl.u});
      qx = $signed({{(NSW-QW){1'b0}}, root_ff[QW-1]});
      sx = $signed({{(NSW-SW){sl.s[SW-1]}}, sl.s});
      n1 = sl.lin ? sx : nu + qx;
      n2 = nu - qx;
      m1 = n1[NSW-1] ? -n1 : n1;
      m2 = n2[NSW-1] ? -n2 : n2;
      sgn1_in   = n1[NSW-1] ^ (sl.aneg && !sl.lin);
      sgn2_in   = n2[NSW-1] ^ sl.aneg;
      nocont_in = sl.lin ? !sl.uneg : negq_ff[QW-1];
   end

   logic sgn1_ff, sgn2_ff, nocont_ff, lin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
      end else if (en) begin
         vn_ff <= vq_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num1_ff   <= {m1, {FRAC_BITS{1'b0}}};
         num2_ff   <= {m2, {FRAC_BITS{1'b0}}};
         den_ff    <= sl.lin ? sl.um : sl.am;
         sgn1_ff   <= sgn1_in;
         sgn2_ff   <= sgn2_in;
         nocont_ff <= nocont_in;
         lin_ff    <= sl.lin;
      end
   end

   logic [TW-1:0] q1, q2;
   logic          ovf1, ovf2;

   wcts_div u_div1 (
      .clock (clock),
      .en    (en),
      .num   (num1_ff),
      .den   (den_ff),
      .quo   (q1),
      .ovf   (ovf1)
   );

   wcts_div u_div2 (
      .clock (clock),
      .en    (en),
      .num   (num2_ff),
      .den   (den_ff),
      .quo   (q2),
      .ovf   (ovf2)
   );

   // flags ride alongside the dividers
   logic vl_ff   [DIV_LAT];
   logic sg1l_ff [DIV_LAT];
   logic sg2l_ff [DIV_LAT];
   logic ncl_ff  [DIV_LAT];
   logic linl_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) vl_ff[i] <= 1'b0;
      end else if (en) begin
         vl_ff[0] <= vn_ff;
         for (int i = 1; i < DIV_LAT; i++) vl_ff[i] <= vl_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sg1l_ff[0] <= sgn1_ff;
         sg2l_ff[0] <= sgn2_ff;
         ncl_ff[0]  <= nocont_ff;
         linl_ff[0] <= lin_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            sg1l_ff[i] <= sg1l_ff[i-1];
            sg2l_ff[i] <= sg2l_ff[i-1];
            ncl_ff[i]  <= ncl_ff[i-1];
            linl_ff[i] <= linl_ff[i-1];
         end
      end
   end

   // signed times and range checks
   logic                 sg1, sg2, lin;
   logic signed [TW:0]   t1, t2;
   logic signed [63:0]   t1x, t2x;
   logic                 ok1_in, ok2_in;
   logic                 vf_ff, ok1_ff, ok2_ff;
   logic signed [TW-1:0] tf1_ff, tf2_ff;

   always_comb begin
      sg1 = sg1l_ff[DIV_LAT-1];
      sg2 = sg2l_ff[DIV_LAT-1];
      lin = linl_ff[DIV_LAT-1];
      t1  = sg1 ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
      t2  = sg2 ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
      t1x = 64'(t1);
      t2x = 64'(t2);
      ok1_in = !ncl_ff[DIV_LAT-1] && !ovf1
             && (sg1 ? (q1 <= {1'b1, {(TW-1){1'b0}}}) : !q1[TW-1])
             && (t1x < TIME_LIMIT)
             && (lin || (!sg1 && (q1 != '0)));
      ok2_in = !ncl_ff[DIV_LAT-1] && !lin && !ovf2 && !sg2 && !q2[TW-1]
             && (q2 != '0) && (t2x < TIME_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff     <= 1'b0;
         out_valid <= 1'b0;
      end else if (en) begin
         vf_ff     <= vl_ff[DIV_LAT-1];
         out_valid <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ok1_ff <= ok1_in;
         ok2_ff <= ok2_in;
         tf1_ff <= t1[TW-1:0];
         tf2_ff <= t2[TW-1:0];
         res.ok <= ok1_ff || ok2_ff;
         if (ok1_ff && ok2_ff) begin
            res.t <= (tf1_ff < tf2_ff) ? tf1_ff : tf2_ff;
         end else begin
            res.t <= ok1_ff ? tf1_ff : tf2_ff;
         end
      end
   end

endmodule

// ===== rtl/wcts_sel.sv =====
// ----------------------------------------------------------------------------
// wcts_sel
// Two-level registered pick of the earliest wall; earlier wall wins a tie.
// ----------------------------------------------------------------------------
module wcts_sel (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  wcts_pkg::wall_res_type        res [wcts_pkg::NWALLS],
   output logic                          out_valid,
   output logic                          hit,
   output logic signed [wcts_pkg::TW-1:0] contact_time,
   output wcts_pkg::wall_code_type       wall_code
);
   import wcts_pkg::*;

   function automatic pick_type choose(pick_type first, pick_type second);
      pick_type r;
      if (second.ok && (!first.ok || (second.t < first.t))) begin
         r = second;
      end else begin
         r = first;
      end
      return r;
   endfunction

   pick_type w0, w1, w2, w3;
   pick_type px_ff, py_ff, fin;
   logic     v1_ff;

   always_comb begin
      w0 = '{ok: res[0].ok, t: res[0].t, code: WALL_UPPER_X};
      w1 = '{ok: res[1].ok, t: res[1].t, code: WALL_LOWER_X};
      w2 = '{ok: res[2].ok, t: res[2].t, code: WALL_UPPER_Y};
      w3 = '{ok: res[3].ok, t: res[3].t, code: WALL_LOWER_Y};
      fin = choose(px_ff, py_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         out_valid <= 1'b0;
      end else if (en) begin
         v1_ff     <= in_valid;
         out_valid <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff        <= choose(w0, w1);
         py_ff        <= choose(w2, w3);
         hit          <= fin.ok;
         contact_time <= fin.ok ? fin.t : '0;
         wall_code    <= fin.ok ? fin.code : WALL_NONE;
      end
   end

endmodule

// ===== rtl/wall_contact_time_solver.sv =====
// ----------------------------------------------------------------------------
// wall_contact_time_solver
// Earliest contact time of one accelerated circular body with four box walls.
// ----------------------------------------------------------------------------
// One body beat enters on the req_ channel (valid/stall) and exactly one
// result beat leaves on the rsp_ channel: hit, contact time and wall code.
// The box bounds are written through the csr_ port; the user must write them
// only while the block is idle, as the block itself does not enforce it. An
// accepted req beat passes through input and gap registers, four product and
// discriminant stages, a 34-stage square root (two discriminant bits per
// stage), a 33-stage divider (one quotient bit per stage), root selection
// and a two-level wall pick; all four walls run in parallel lanes. Throughput
// is one body per cycle unless rsp_stall is high while a result is shown:
// then the whole pipeline holds and req_stall rises in the same cycle, so
// nothing is lost or repeated. Synchronous reset clears all valid bits and
// sets the box to 0..100.0 in both axes.
// ----------------------------------------------------------------------------
module wall_contact_time_solver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [wcts_pkg::XW-1:0]      req_pos_x,
   input  logic signed [wcts_pkg::XW-1:0]      req_pos_y,
   input  logic signed [wcts_pkg::XW-1:0]      req_vel_x,
   input  logic signed [wcts_pkg::XW-1:0]      req_vel_y,
   input  logic signed [wcts_pkg::XW-1:0]      req_acc_x,
   input  logic signed [wcts_pkg::XW-1:0]      req_acc_y,
   input  logic [wcts_pkg::RADW-1:0]           req_body_radius,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic signed [wcts_pkg::TW-1:0]      rsp_contact_time,
   output logic [2:0]                          rsp_wall_code,
   input  logic                                csr_we,
   input  logic [wcts_pkg::CSR_IW-1:0]         csr_index,
   input  logic [wcts_pkg::XW-1:0]             csr_wdata
);
   import wcts_pkg::*;

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // box registers
   logic signed [XW-1:0] box_left_ff, box_right_ff, box_bottom_ff, box_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff   <= BOX_LEFT_RESET;
         box_right_ff  <= BOX_RIGHT_RESET;
         box_bottom_ff <= BOX_BOTTOM_RESET;
         box_top_ff    <= BOX_TOP_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BOX_LEFT:   box_left_ff   <= csr_wdata;
            CSR_BOX_RIGHT:  box_right_ff  <= csr_wdata;
            CSR_BOX_BOTTOM: box_bottom_ff <= csr_wdata;
            CSR_BOX_TOP:    box_top_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input beat register
   logic                 vi_ff;
   logic signed [XW-1:0] px_ff, py_ff, vx_ff, vy_ff, ax_ff, ay_ff;
   logic [RADW-1:0]      r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vi_ff <= 1'b0;
      end else if (en) begin
         vi_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
         vx_ff <= req_vel_x;
         vy_ff <= req_vel_y;
         ax_ff <= req_acc_x;
         ay_ff <= req_acc_y;
         r_ff  <= req_body_radius;
      end
   end

   // gaps, closing rates and accelerations
   logic signed [SW-1:0] ex_px, ex_py, ex_r, ex_l, ex_rt, ex_b, ex_t;
   logic signed [UW-1:0] ex_vx, ex_vy, ex_ax, ex_ay;
   logic signed [SW-1:0] s_in [NWALLS];
   logic signed [UW-1:0] u_in [NWALLS];
   logic signed [UW-1:0] a_in [NWALLS];
   logic signed [SW-1:0] s_ff [NWALLS];
   logic signed [UW-1:0] u_ff [NWALLS];
   logic signed [UW-1:0] a_ff [NWALLS];
   logic                 vs_ff;

   always_comb begin
      ex_px = SW'(px_ff);
      ex_py = SW'(py_ff);
      ex_r  = $signed({{(SW-RADW){1'b0}}, r_ff});
      ex_l  = SW'(box_left_ff);
      ex_rt = SW'(box_right_ff);
      ex_b  = SW'(box_bottom_ff);
      ex_t  = SW'(box_top_ff);
      ex_vx = UW'(vx_ff);
      ex_vy = UW'(vy_ff);
      ex_ax = UW'(ax_ff);
      ex_ay = UW'(ay_ff);
      s_in[0] = ex_rt - ex_px - ex_r;  u_in[0] = -ex_vx;  a_in[0] = -ex_ax;
      s_in[1] = ex_px - ex_l - ex_r;   u_in[1] = ex_vx;   a_in[1] = ex_ax;
      s_in[2] = ex_t - ex_py - ex_r;   u_in[2] = -ex_vy;  a_in[2] = -ex_ay;
      s_in[3] = ex_py - ex_b - ex_r;   u_in[3] = ex_vy;   a_in[3] = ex_ay;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
      end else if (en) begin
         vs_ff <= vi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int w = 0; w < NWALLS; w++) begin
            s_ff[w] <= s_in[w];
            u_ff[w] <= u_in[w];
            a_ff[w] <= a_in[w];
         end
      end
   end

   // wall lanes
   logic         wv [NWALLS];
   wall_res_type wres [NWALLS];

   for (genvar w = 0; w < NWALLS; w++) begin : g_wall
      wcts_wall u_wall (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (vs_ff),
         .wall_s    (s_ff[w]),
         .wall_u    (u_ff[w]),
         .wall_a    (a_ff[w]),
         .out_valid (wv[w]),
         .res       (wres[w])
      );
   end

   wall_code_type code;

   wcts_sel u_sel (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (wv[0]),
      .res          (wres),
      .out_valid    (rsp_valid),
      .hit          (rsp_hit),
      .contact_time (rsp_contact_time),
      .wall_code    (code)
   );

   assign rsp_wall_code = code;

endmodule

// ===== rtl/wcts_checker.sv =====
// ----------------------------------------------------------------------------
// wcts_checker
// Port-level checks of the wall contact time solver, bound to the top level.
// ----------------------------------------------------------------------------
module wcts_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_hit,
   input logic signed [wcts_pkg::TW-1:0] rsp_contact_time,
   input logic [2:0]                     rsp_wall_code
);
   import wcts_pkg::*;

   // held beat stays
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped under stall");

   a_hold_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_contact_time) && $stable(rsp_wall_code))
      else $error("rsp beat changed under stall");

   a_hit_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit == (rsp_wall_code != WALL_NONE))
      else $error("hit and wall code disagree");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_contact_time == '0)
      else $error("contact time not zero on a miss");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

endmodule

bind wall_contact_time_solver wcts_checker u_wcts_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_hit          (rsp_hit),
   .rsp_contact_time (rsp_contact_time),
   .rsp_wall_code    (rsp_wall_code)
);

// ===== tb/sv/wall_contact_time_solver_tb.sv =====
// ----------------------------------------------------------------------------
// wall_contact_time_solver_tb
// Self-checking bench for the wall contact time solver.
// ----------------------------------------------------------------------------
// A short table of directed bodies is followed by random bodies under three
// box settings and three idling patterns. Known rows carry their own results,
// a model predicts the rest; results are compared field by field, in order.
// ----------------------------------------------------------------------------
module wall_contact_time_solver_tb;
   import wcts_pkg::*;

   localparam int Q         = 1 << FRAC_BITS;
   localparam int LATENCY   = 78;
   localparam int PHASE_LEN = 300;

   typedef struct {
      logic signed [XW-1:0] px, py, vx, vy, ax, ay;
      logic [RADW-1:0]      rad;
   } body_type;

   typedef struct {
      logic                 hit;
      logic signed [TW-1:0] t;
      wall_code_type        code;
   } contact_type;

   typedef struct {
      logic signed [XW-1:0] px, py, vx, vy, ax, ay;
      logic [RADW-1:0]      rad;
      bit                   known;
      logic                 hit;
      logic signed [TW-1:0] t;
      wall_code_type        code;
   } row_type;

   localparam int NROWS = 16;
   row_type dir_rows [NROWS] = '{
      '{50*Q, 50*Q, 0, 0, 0, 0, 0, 1, 0, 0, WALL_NONE},
      '{50*Q, 50*Q, Q, 0, 0, 0, 0, 1, 1, 50*Q, WALL_UPPER_X},
      '{50*Q, 50*Q, -Q, 0, 0, 0, 0, 1, 1, 50*Q, WALL_LOWER_X},
      '{50*Q, 50*Q, 0, Q, 0, 0, 0, 1, 1, 50*Q, WALL_UPPER_Y},
      '{50*Q, 50*Q, 0, -Q, 0, 0, 0, 1, 1, 50*Q, WALL_LOWER_Y},
      '{-10*Q, 50*Q, -Q, 0, 0, 0, 0, 1, 1, -10*Q, WALL_LOWER_X},
      '{50*Q, 50*Q, Q, Q, 0, 0, 0, 1, 1, 50*Q, WALL_UPPER_X},
      '{50*Q, 50*Q, 0, 0, 0, 0, RADW'(50*Q), 1, 0, 0, WALL_NONE},
      '{50*Q, 50*Q, Q, 0, 0, 0, RADW'(50*Q), 1, 1, 0, WALL_UPPER_X},
      '{50*Q, 50*Q, 1, 0, 0, 0, 0, 1, 0, 0, WALL_NONE},
      '{50*Q, 50*Q, 32'sh80000000, 0, 0, 0, 0, 1, 1, 100, WALL_LOWER_X},
      '{50*Q, 50*Q, 0, 0, Q, -2*Q, 0, 0, 0, 0, WALL_NONE},
      '{50*Q, 50*Q, -5*Q, 3*Q, Q/4, -Q/8, RADW'(2*Q), 0, 0, 0, WALL_NONE},
      '{50*Q, 50*Q, 0, 0, 0, 0, 31'h7fffffff, 0, 0, 0, WALL_NONE},
      '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
        32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 0, 0, 0, WALL_NONE},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
        32'sh80000000, 32'sh80000000, 0, 0, 0, 0, WALL_NONE}
   };

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_stall;
   logic signed [XW-1:0] req_pos_x = 0, req_pos_y = 0, req_vel_x = 0, req_vel_y = 0;
   logic signed [XW-1:0] req_acc_x = 0, req_acc_y = 0;
   logic [RADW-1:0]      req_body_radius = 0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   logic                 rsp_hit;
   logic signed [TW-1:0] rsp_contact_time;
   logic [2:0]           rsp_wall_code;
   logic                 csr_we = 0;
   logic [CSR_IW-1:0]    csr_index = '0;
   logic [XW-1:0]        csr_wdata = '0;

   logic signed [XW-1:0] box_left   = BOX_LEFT_RESET;
   logic signed [XW-1:0] box_right  = BOX_RIGHT_RESET;
   logic signed [XW-1:0] box_bottom = BOX_BOTTOM_RESET;
   logic signed [XW-1:0] box_top    = BOX_TOP_RESET;

   contact_type pending_contacts[$];
   bit          drive_known = 0;
   contact_type drive_contact;
   int          error_count = 0;
   int          sender_idle_pct = 37;
   int          receiver_idle_pct = 57;

   wall_contact_time_solver i_dut (.*);

   always #4 clock = ~clock;

   function automatic bit wall_time(longint s, longint u, longint a, output longint t);
      logic signed [127:0] uw, aw, sw, d;
      logic [127:0]        root, cand;
      longint              q, r1, r2;
      bit                  v1, v2;
      t = 0;
      if (a == 0) begin
         if (u >= 0) return 0;
         t = (s * Q) / (-u);
         return t >= -64'sd2147483648 && t <= 64'sd2147483647 && t < TIME_LIMIT;
      end
      uw = u;
      aw = a;
      sw = s;
      d = uw * uw - 2 * aw * sw;
      if (d < 0) return 0;
      root = 0;
      for (int b = 35; b >= 0; b--) begin
         cand = root | (128'd1 << b);
         if (cand * cand <= $unsigned(d)) root = cand;
      end
      q = root[63:0];
      r1 = ((-u + q) * Q) / a;
      r2 = ((-u - q) * Q) / a;
      v1 = r1 > 0 && r1 <= 64'sd2147483647 && r1 < TIME_LIMIT;
      v2 = r2 > 0 && r2 <= 64'sd2147483647 && r2 < TIME_LIMIT;
      if (v1 && v2) t = r1 < r2 ? r1 : r2;
      else if (v1) t = r1;
      else if (v2) t = r2;
      return v1 || v2;
   endfunction

   function automatic contact_type earliest_contact(body_type b);
      longint      s[4], u[4], a[4];
      longint      r, t, best;
      contact_type c;
      r = longint'(b.rad);
      s[0] = longint'(box_right) - b.px - r;  u[0] = -longint'(b.vx); a[0] = -longint'(b.ax);
      s[1] = longint'(b.px) - box_left - r;   u[1] = b.vx;            a[1] = b.ax;
      s[2] = longint'(box_top) - b.py - r;    u[2] = -longint'(b.vy); a[2] = -longint'(b.ay);
      s[3] = longint'(b.py) - box_bottom - r; u[3] = b.vy;            a[3] = b.ay;
      c = '{0, 0, WALL_NONE};
      best = 0;
      for (int w = 0; w < NWALLS; w++)
         if (wall_time(s[w], u[w], a[w], t) && (c.code == WALL_NONE || t < best)) begin
            best = t;
            c.code = wall_code_type'(w + 1);
         end
      c.hit = c.code != WALL_NONE;
      c.t = best[31:0];
      return c;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      contact_type want;
      body_type    b;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            b = '{req_pos_x, req_pos_y, req_vel_x, req_vel_y, req_acc_x, req_acc_y,
                  req_body_radius};
            want = drive_known ? drive_contact : earliest_contact(b);
            pending_contacts = {pending_contacts, want};
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_contacts.size() == 0) begin
               $display("unexpected result beat at %0t", $realtime);
               error_count++;
            end else begin
               want = pending_contacts.pop_front();
               if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
               if (rsp_contact_time !== want.t)
                  report_mismatch("contact_time", rsp_contact_time, want.t);
               if (rsp_wall_code !== want.code)
                  report_mismatch("wall_code", rsp_wall_code, want.code);
            end
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= !reset && $urandom_range(99) < receiver_idle_pct;

   task automatic send_body(body_type b, bit known, contact_type c);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid       <= 1;
      req_pos_x       <= b.px;
      req_pos_y       <= b.py;
      req_vel_x       <= b.vx;
      req_vel_y       <= b.vy;
      req_acc_x       <= b.ax;
      req_acc_y       <= b.ay;
      req_body_radius <= b.rad;
      drive_known     <= known;
      drive_contact   <= c;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(negedge clock);
      while (pending_contacts.size() != 0) @(negedge clock);
   endtask

   // write enable stays high across a run of writes; the caller drops it
   task automatic write_box(csr_index_type idx, logic [XW-1:0] value);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_BOX_LEFT:   box_left   = value;
         CSR_BOX_RIGHT:  box_right  = value;
         CSR_BOX_BOTTOM: box_bottom = value;
         CSR_BOX_TOP:    box_top    = value;
      endcase
      @(negedge clock);
   endtask

   function automatic logic signed [XW-1:0] near_q(int span);
      return ($signed($urandom_range(0, 2 * span)) - span) * Q + $urandom_range(0, Q - 1);
   endfunction

   function automatic body_type random_body();
      body_type b;
      if ($urandom_range(99) < 20) begin
         b = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               RADW'($urandom)};
      end else begin
         b.px  = near_q(150);
         b.py  = near_q(150);
         b.vx  = $urandom_range(9) == 0 ? 0 : near_q(20);
         b.vy  = $urandom_range(9) == 0 ? 0 : near_q(20);
         b.ax  = $urandom_range(2) == 0 ? 0 : near_q(4);
         b.ay  = $urandom_range(2) == 0 ? 0 : near_q(4);
         b.rad = RADW'($urandom_range(0, 5 * Q));
      end
      return b;
   endfunction

   initial begin
      body_type    b;
      contact_type c;
      int          lo;
      repeat (6) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      foreach (dir_rows[i]) begin
         b = '{dir_rows[i].px, dir_rows[i].py, dir_rows[i].vx, dir_rows[i].vy,
               dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].rad};
         c = '{dir_rows[i].hit, dir_rows[i].t, dir_rows[i].code};
         send_body(b, dir_rows[i].known, c);
      end
      for (int phase = 0; phase < 3; phase++) begin
         drain();
         sender_idle_pct   = phase == 0 ? 37 : phase == 1 ? 57 : 0;
         receiver_idle_pct = phase == 0 ? 57 : phase == 1 ? 37 : 0;
         case (phase)
            0: begin
               lo = $urandom_range(0, 50);
               write_box(CSR_BOX_LEFT, XW'((lo - 20) * Q));
               write_box(CSR_BOX_RIGHT, XW'((lo + $urandom_range(1, 150)) * Q));
               write_box(CSR_BOX_BOTTOM, XW'((lo - 30) * Q));
               write_box(CSR_BOX_TOP, XW'((lo + $urandom_range(1, 150)) * Q));
            end
            1: begin
               write_box(CSR_BOX_LEFT, 32'h80000000);
               write_box(CSR_BOX_RIGHT, 32'h7fffffff);
               write_box(CSR_BOX_BOTTOM, 32'h7fffffff);
               write_box(CSR_BOX_TOP, 32'h80000000);
            end
            default: begin
               write_box(CSR_BOX_LEFT, $urandom);
               write_box(CSR_BOX_RIGHT, $urandom);
               write_box(CSR_BOX_BOTTOM, $urandom);
               write_box(CSR_BOX_TOP, $urandom);
            end
         endcase
         csr_we <= 0;
         for (int n = 0; n < PHASE_LEN; n++) begin
            if (phase == 0 && n == PHASE_LEN / 2) drain();
            send_body(random_body(), 0, c);
         end
      end
      drain();
      repeat (LATENCY + 20) @(negedge clock);
      if (error_count == 0 && pending_contacts.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(8 * 400000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
